// ----- rtl/apdt_pkg.sv -----
// Shared types, widths and helpers for the affine point/direction transform.
// Used by every module in rtl; depends on nothing.
package apdt_pkg;

    localparam int CW       = 20;
    localparam int KW       = 16;
    localparam int PROD_W   = CW + KW;
    localparam int SH_W     = PROD_W - 12;
    localparam int SUM_W    = 26;
    localparam int PT_W     = SUM_W + 1;
    localparam int SQ_W     = 48;
    localparam int SS_W     = 49;
    localparam int RAD_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int REM_W    = 33;
    localparam int MAG_W    = 24;
    localparam int NUM_W    = MAG_W + 16;
    localparam int QUO_W    = 11;
    localparam int ROW_W    = 48;
    localparam int TRANS_W  = 60;
    localparam int CFG_W    = 60;
    localparam int IDX_W    = 3;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = QUO_W;

    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

    typedef enum logic [IDX_W-1:0] {
        CFG_ROW_X = 3'd0,
        CFG_ROW_Y = 3'd1,
        CFG_ROW_Z = 3'd2,
        CFG_TRANS = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              mode;
        logic signed [CW-1:0] in_x;
        logic signed [CW-1:0] in_y;
        logic signed [CW-1:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic              zero_length;
    } t_out_item;

    typedef struct packed {
        logic [2:0][ROW_W-1:0] row;
        logic [TRANS_W-1:0]    trans;
    } t_cfg;

    typedef struct packed {
        logic                  mode;
        logic                  zero;
        logic [2:0][CW-1:0]    pt;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        t_side             side;
    } t_sqrt_st;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][QUO_W-1:0] quo;
        logic [ROOT_W-1:0]     den;
        t_side                 side;
    } t_div_st;

    function automatic logic signed [CW-1:0] sat20(input logic signed [PT_W-1:0] v);
        logic signed [PT_W-1:0] hi;
        logic signed [PT_W-1:0] lo;
        hi = PT_W'(524287);
        lo = -PT_W'(524288);
        if (v > hi) begin
            return CW'(hi);
        end else if (v < lo) begin
            return CW'(lo);
        end
        return CW'(v);
    endfunction

endpackage

// ----- rtl/apdt_matvec.sv -----
// Matrix-vector front end: products, row sums, point results, squared length.
// Four register stages; depends on apdt_pkg.
module apdt_matvec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  apdt_pkg::t_in_item         i_item,
    input  apdt_pkg::t_cfg             i_cfg,
    output logic                       o_valid,
    output apdt_pkg::t_side            o_side,
    output logic [apdt_pkg::SS_W-1:0]  o_ss
);

    logic signed [apdt_pkg::CW-1:0]     coord [3];
    logic signed [apdt_pkg::PROD_W-1:0] n_prod [3][3];
    logic signed [apdt_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [apdt_pkg::SUM_W-1:0]  n_sum [3];
    logic signed [apdt_pkg::SUM_W-1:0]  r_sum [3];
    logic signed [apdt_pkg::SUM_W-1:0]  r_sum3 [3];
    logic signed [2*apdt_pkg::SUM_W-1:0] n_sq [3];
    logic [apdt_pkg::SQ_W-1:0]          r_sq [3];
    logic [2:0][apdt_pkg::CW-1:0]       n_pt;
    logic [2:0][apdt_pkg::CW-1:0]       r_pt;
    logic [apdt_pkg::SS_W-1:0]          n_ss;
    apdt_pkg::t_side                    n_side;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_m1, r_m2, r_m3;

    always_comb begin
        coord[0] = i_item.in_x;
        coord[1] = i_item.in_y;
        coord[2] = i_item.in_z;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[j][k] = coord[k] * $signed(i_cfg.row[j][apdt_pkg::KW*k +: apdt_pkg::KW]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sum[j] = apdt_pkg::SUM_W'($signed(r_prod[j][0][apdt_pkg::PROD_W-1:12]))
                     + apdt_pkg::SUM_W'($signed(r_prod[j][1][apdt_pkg::PROD_W-1:12]))
                     + apdt_pkg::SUM_W'($signed(r_prod[j][2][apdt_pkg::PROD_W-1:12]));
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sq[j] = r_sum[j] * r_sum[j];
            n_pt[j] = apdt_pkg::sat20(apdt_pkg::PT_W'(r_sum[j])
                + apdt_pkg::PT_W'($signed(i_cfg.trans[apdt_pkg::CW*j +: apdt_pkg::CW])));
        end
    end

    always_comb begin
        n_ss = apdt_pkg::SS_W'(r_sq[0]) + apdt_pkg::SS_W'(r_sq[1]) + apdt_pkg::SS_W'(r_sq[2]);
        n_side.mode = r_m3;
        n_side.zero = (n_ss == '0);
        n_side.pt   = r_pt;
        for (int j = 0; j < 3; j++) begin
            n_side.neg[j] = r_sum3[j][apdt_pkg::SUM_W-1];
            n_side.mag[j] = r_sum3[j][apdt_pkg::SUM_W-1]
                ? apdt_pkg::MAG_W'(-r_sum3[j]) : apdt_pkg::MAG_W'(r_sum3[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_m1   <= i_item.mode;
            r_sum  <= n_sum;
            r_m2   <= r_m1;
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= n_sq[j][apdt_pkg::SQ_W-1:0];
            end
            r_sum3 <= r_sum;
            r_pt   <= n_pt;
            r_m3   <= r_m2;
            o_side <= n_side;
            o_ss   <= n_ss;
        end
    end

    assign o_valid = r_v4;

endmodule

// ----- rtl/apdt_sqrt_step.sv -----
// One registered step of the digit-by-digit integer square root.
// Resolves one root bit per stage; depends on apdt_pkg.
module apdt_sqrt_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  apdt_pkg::t_sqrt_st  i_st,
    output logic                o_valid,
    output apdt_pkg::t_sqrt_st  o_st
);

    logic [apdt_pkg::REM_W+1:0] rem2;
    logic [apdt_pkg::REM_W+1:0] trial;
    apdt_pkg::t_sqrt_st         n_st;

    always_comb begin
        rem2  = {i_st.rem, i_st.rad[apdt_pkg::RAD_W-1 -: 2]};
        trial = (apdt_pkg::REM_W+2)'({i_st.root, 2'b01});
        n_st      = i_st;
        n_st.rad  = {i_st.rad[apdt_pkg::RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            n_st.rem  = apdt_pkg::REM_W'(rem2 - trial);
            n_st.root = {i_st.root[apdt_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_st.rem  = apdt_pkg::REM_W'(rem2);
            n_st.root = {i_st.root[apdt_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_st <= n_st;
        end
    end

endmodule

// ----- rtl/apdt_div_step.sv -----
// One registered step of the three-lane restoring divider.
// Resolves quotient bit BIT of every lane; depends on apdt_pkg.
module apdt_div_step #(
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  apdt_pkg::t_div_st  i_st,
    output logic               o_valid,
    output apdt_pkg::t_div_st  o_st
);

    logic [apdt_pkg::NUM_W:0] dsh;
    apdt_pkg::t_div_st        n_st;

    always_comb begin
        dsh  = (apdt_pkg::NUM_W+1)'(i_st.den) << BIT;
        n_st = i_st;
        for (int j = 0; j < 3; j++) begin
            if ((apdt_pkg::NUM_W+1)'(i_st.rem[j]) >= dsh) begin
                n_st.rem[j]      = apdt_pkg::NUM_W'((apdt_pkg::NUM_W+1)'(i_st.rem[j]) - dsh);
                n_st.quo[j][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_st <= n_st;
        end
    end

endmodule

// ----- rtl/affine_point_direction_transform_top.sv -----
// Top level of the affine point/direction transform: config registers, pipeline, output.
// Depends on apdt_pkg, apdt_matvec, apdt_sqrt_step, apdt_div_step.
//
// Input channel: i_in_valid / o_in_stall carry a mode bit and a Q10.10 point.
// Output channel: o_out_valid / i_out_stall carry the Q10.10 result and the
// zero_length flag. One result per input transaction, in order.
// Point mode: 3x3 coefficient matrix times the point plus translation, saturated.
// Direction mode: product normalized to unit length; zero vector gives zeros and
// zero_length.
// The pipeline has 4 matrix stages, 31 square-root stages (one root bit each),
// 11 divider stages (one quotient bit each) and the output register.
// Throughput is one transaction per cycle while the receiver does not stall a held result.
// When the receiver stalls a held result, the whole pipeline holds and o_in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Configuration writes use i_cfg_wr_en / i_cfg_index / i_cfg_data; the user must
// issue them only while the pipeline is empty, which the block does not enforce.
// Indexes above 3 are ignored. Synchronous reset clears all valid bits and loads the
// identity matrix and zero translation.
module affine_point_direction_transform_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  apdt_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output apdt_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [apdt_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [apdt_pkg::CFG_W-1:0]    i_cfg_data
);

    apdt_pkg::t_cfg             r_cfg;
    logic                       en;
    logic                       mv_valid;
    apdt_pkg::t_side            mv_side;
    logic [apdt_pkg::SS_W-1:0]  mv_ss;
    wire                        w_sq_vld [0:apdt_pkg::SQ_STAGES];
    wire apdt_pkg::t_sqrt_st    w_sq_st  [0:apdt_pkg::SQ_STAGES];
    wire                        w_dv_vld [0:apdt_pkg::DIV_STAGES];
    wire apdt_pkg::t_div_st     w_dv_st  [0:apdt_pkg::DIV_STAGES];
    apdt_pkg::t_sqrt_st         sq_in;
    apdt_pkg::t_div_st          dv_in;
    apdt_pkg::t_out_item        n_out;
    apdt_pkg::t_div_st          dv_last;
    logic signed [apdt_pkg::CW-1:0] lane_val [3];
    logic                       r_out_valid;
    apdt_pkg::t_out_item        r_out;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row[0] <= apdt_pkg::ROW_X_RST;
            r_cfg.row[1] <= apdt_pkg::ROW_Y_RST;
            r_cfg.row[2] <= apdt_pkg::ROW_Z_RST;
            r_cfg.trans  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                apdt_pkg::CFG_ROW_X: r_cfg.row[0] <= i_cfg_data[apdt_pkg::ROW_W-1:0];
                apdt_pkg::CFG_ROW_Y: r_cfg.row[1] <= i_cfg_data[apdt_pkg::ROW_W-1:0];
                apdt_pkg::CFG_ROW_Z: r_cfg.row[2] <= i_cfg_data[apdt_pkg::ROW_W-1:0];
                apdt_pkg::CFG_TRANS: r_cfg.trans  <= i_cfg_data[apdt_pkg::TRANS_W-1:0];
                default: ;
            endcase
        end
    end

    apdt_matvec u_matvec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (mv_valid),
        .o_side  (mv_side),
        .o_ss    (mv_ss)
    );

    always_comb begin
        sq_in.rem  = '0;
        sq_in.root = '0;
        sq_in.rad  = {1'b0, mv_ss, 12'b0};
        sq_in.side = mv_side;
    end

    assign w_sq_vld[0] = mv_valid;
    assign w_sq_st[0]  = sq_in;

    for (genvar g = 0; g < apdt_pkg::SQ_STAGES; g++) begin : g_sqrt
        apdt_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_vld[g]),
            .i_st    (w_sq_st[g]),
            .o_valid (w_sq_vld[g+1]),
            .o_st    (w_sq_st[g+1])
        );
    end

    always_comb begin
        dv_in.den  = w_sq_st[apdt_pkg::SQ_STAGES].root;
        dv_in.side = w_sq_st[apdt_pkg::SQ_STAGES].side;
        dv_in.quo  = '0;
        for (int j = 0; j < 3; j++) begin
            dv_in.rem[j] = {w_sq_st[apdt_pkg::SQ_STAGES].side.mag[j], 16'b0};
        end
    end

    assign w_dv_vld[0] = w_sq_vld[apdt_pkg::SQ_STAGES];
    assign w_dv_st[0]  = dv_in;

    for (genvar g = 0; g < apdt_pkg::DIV_STAGES; g++) begin : g_div
        apdt_div_step #(
            .BIT (apdt_pkg::QUO_W - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_dv_vld[g]),
            .i_st    (w_dv_st[g]),
            .o_valid (w_dv_vld[g+1]),
            .o_st    (w_dv_st[g+1])
        );
    end

    assign dv_last = w_dv_st[apdt_pkg::DIV_STAGES];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            lane_val[j] = dv_last.side.neg[j] ? -apdt_pkg::CW'(dv_last.quo[j])
                                              : apdt_pkg::CW'(dv_last.quo[j]);
            if (!dv_last.side.mode) begin
                lane_val[j] = dv_last.side.pt[j];
            end else if (dv_last.side.zero) begin
                lane_val[j] = '0;
            end
        end
        n_out.out_x       = lane_val[0];
        n_out.out_y       = lane_val[1];
        n_out.out_z       = lane_val[2];
        n_out.zero_length = dv_last.side.mode && dv_last.side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_dv_vld[apdt_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/apdt_chk.sv -----
// Port-level checks for affine_point_direction_transform_top, bound to the top level.
// Depends on apdt_pkg.
module apdt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input apdt_pkg::t_out_item           o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.zero_length) |->
        (o_out_data.out_x == '0 && o_out_data.out_y == '0 && o_out_data.out_z == '0))
        else $error("zero_length with nonzero result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind affine_point_direction_transform_top apdt_chk u_apdt_chk (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for affine_point_direction_transform_top.
// Predicts each result from the register image and checks outputs in order.
// Depends on apdt_pkg and the RTL under rtl.
`timescale 1ns / 100ps

module testbench;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    apdt_pkg::t_in_item          i_in_data = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    apdt_pkg::t_out_item         o_out_data;
    logic                        i_cfg_wr_en = 1'b0;
    logic [apdt_pkg::IDX_W-1:0]  i_cfg_index = '0;
    logic [apdt_pkg::CFG_W-1:0]  i_cfg_data = '0;

    logic [apdt_pkg::ROW_W-1:0]   coef_row [3];
    logic [apdt_pkg::TRANS_W-1:0] offset_reg;
    apdt_pkg::t_out_item          expected_q [$];
    int                 error_count = 0;
    int                 max_gap = 18;
    int                 max_stall = 18;

    affine_point_direction_transform_top u_top (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint shr12_floor(longint v);
        return v >>> 12;
    endfunction

    function automatic logic [apdt_pkg::CW-1:0] clamp20(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[apdt_pkg::CW-1:0];
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint unit_lane(longint s, longint len);
        longint unsigned m;
        longint q;
        m = (s < 0) ? -s : s;
        q = longint'((m << 16) / len);
        return (s < 0) ? -q : q;
    endfunction

    function automatic apdt_pkg::t_out_item transform_point(apdt_pkg::t_in_item it);
        longint c [3];
        longint s [3];
        longint unsigned ss;
        longint len;
        apdt_pkg::t_out_item r;
        c[0] = longint'(it.in_x);
        c[1] = longint'(it.in_y);
        c[2] = longint'(it.in_z);
        r = '0;
        for (int j = 0; j < 3; j++) begin
            s[j] = 0;
            for (int k = 0; k < 3; k++)
                s[j] += shr12_floor(c[k] * longint'($signed(coef_row[j][16*k +: 16])));
        end
        if (!it.mode) begin
            r.out_x = clamp20(s[0] + longint'($signed(offset_reg[19:0])));
            r.out_y = clamp20(s[1] + longint'($signed(offset_reg[39:20])));
            r.out_z = clamp20(s[2] + longint'($signed(offset_reg[59:40])));
        end else begin
            ss = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
            if (ss == 0) begin
                r.zero_length = 1'b1;
            end else begin
                len = root_floor(ss << 12);
                r.out_x = clamp20(unit_lane(s[0], len));
                r.out_y = clamp20(unit_lane(s[1], len));
                r.out_z = clamp20(unit_lane(s[2], len));
            end
        end
        return r;
    endfunction

    task automatic write_reg(apdt_pkg::t_cfg_idx idx, logic [apdt_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            apdt_pkg::CFG_ROW_X: coef_row[0] = val[apdt_pkg::ROW_W-1:0];
            apdt_pkg::CFG_ROW_Y: coef_row[1] = val[apdt_pkg::ROW_W-1:0];
            apdt_pkg::CFG_ROW_Z: coef_row[2] = val[apdt_pkg::ROW_W-1:0];
            apdt_pkg::CFG_TRANS: offset_reg = val[apdt_pkg::TRANS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(apdt_pkg::t_in_item it);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(transform_point(it));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                error_count++;
            end else begin
                apdt_pkg::t_out_item e;
                e = expected_q.pop_front();
                if (e.out_x !== o_out_data.out_x || e.out_y !== o_out_data.out_y ||
                    e.out_z !== o_out_data.out_z ||
                    e.zero_length !== o_out_data.zero_length) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, o_out_data);
                    error_count++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (max_stall > 0 && $urandom_range(3, 0) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(max_stall, 1) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic apdt_pkg::t_in_item rand_item(int bound);
        apdt_pkg::t_in_item it;
        it.mode = 1'($urandom_range(1, 0));
        it.in_x = apdt_pkg::CW'($signed($urandom_range(2 * bound, 0)) - bound);
        it.in_y = apdt_pkg::CW'($signed($urandom_range(2 * bound, 0)) - bound);
        it.in_z = apdt_pkg::CW'($signed($urandom_range(2 * bound, 0)) - bound);
        if ($urandom_range(7, 0) == 0) it.in_x = apdt_pkg::CW'($urandom);
        return it;
    endfunction

    function automatic logic [apdt_pkg::ROW_W-1:0] rand_row();
        logic [apdt_pkg::ROW_W-1:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                         : 16'($signed($urandom_range(16384, 0)) - 8192);
        return r;
    endfunction

    task automatic test_directed();
        logic signed [apdt_pkg::CW-1:0] ext [4];
        ext = '{20'sh80000, 20'sh7FFFF, 20'sd0, -20'sd1};
        send_item('{1'b1, 20'sd0, 20'sd0, 20'sd0});
        send_item('{1'b0, 20'sd0, 20'sd0, 20'sd0});
        for (int m = 0; m < 2; m++)
            for (int a = 0; a < 4; a++)
                send_item('{m[0], ext[a], ext[(a + 1) % 4], ext[(a + 2) % 4]});
        send_item('{1'b1, 20'sd1, 20'sd0, 20'sd0});
        send_item('{1'b1, -20'sd3, 20'sd4, 20'sd0});
        drain();
    endtask

    task automatic test_extreme_config();
        write_reg(apdt_pkg::CFG_ROW_X, 60'hFFF_7FFF_7FFF_7FFF);
        write_reg(apdt_pkg::CFG_ROW_Y, {12'h0, 48'h8000_8000_8000});
        write_reg(apdt_pkg::CFG_ROW_Z, 60'h0);
        write_reg(apdt_pkg::CFG_TRANS, {20'h7FFFF, 20'h80000, 20'h7FFFF});
        for (int i = 0; i < 12; i++) send_item(rand_item(524287));
        send_item('{1'b1, 20'sd0, 20'sd0, 20'sd0});
        send_item('{1'b1, 20'sd5, 20'sd5, 20'sd5});
        drain();
        write_reg(apdt_pkg::t_cfg_idx'(3'd5), 60'hABC);
        write_reg(apdt_pkg::CFG_TRANS, {apdt_pkg::TRANS_W{1'b1}});
        for (int i = 0; i < 6; i++) send_item(rand_item(524287));
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(apdt_pkg::CFG_ROW_X, rand_row());
            write_reg(apdt_pkg::CFG_ROW_Y, rand_row());
            write_reg(apdt_pkg::CFG_ROW_Z, rand_row());
            write_reg(apdt_pkg::CFG_TRANS, apdt_pkg::CFG_W'({$urandom, $urandom}));
            max_gap = (ph % 3 == 0) ? 0 : 18;
            max_stall = (ph % 4 == 1) ? 0 : 18;
            for (int i = 0; i < 68; i++)
                send_item(rand_item((i % 2) ? 524287 : $urandom_range(4096, 1)));
            drain();
        end
    endtask

    initial begin
        coef_row[0] = apdt_pkg::ROW_X_RST;
        coef_row[1] = apdt_pkg::ROW_Y_RST;
        coef_row[2] = apdt_pkg::ROW_Z_RST;
        offset_reg = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_extreme_config();
        test_random();
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
